### rtl/core/camera_view_transform_unit_macros.svh
// Assertion macros for the camera view transform block.
`ifndef CAMERA_VIEW_TRANSFORM_UNIT_MACROS_SVH
`define CAMERA_VIEW_TRANSFORM_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define CVT_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
`define CVT_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define CVT_ASSERT_NOW(label, pre, post)
`define CVT_ASSERT_NEXT(label, pre, post)
`endif
`endif

### rtl/core/cvt_pkg.sv
// Shared constants, types and trig helpers for the camera view transform.
package cvt_pkg;

    localparam int COORD_BITS_DEF     = 16;
    localparam int TRIG_FRAC_BITS_DEF = 14;
    localparam int ANG_W              = 9;
    localparam int CFG_IDX_W          = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_POS_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ANG_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ANG_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ANG_Z = 3'd5;

    localparam logic [9:0] DEG_90  = 10'd90;
    localparam logic [9:0] DEG_180 = 10'd180;
    localparam logic [9:0] DEG_270 = 10'd270;
    localparam logic [9:0] DEG_360 = 10'd360;

    localparam real PI_R      = 3.14159265358979323846;
    localparam real HALF_TURN = 180.0;

    // table index (0..90) and sign for a folded angle
    typedef struct packed {
        logic [6:0] idx;
        logic       neg;
    } t_trig_sel;

    // round(sin(k deg) * 2^frac), evaluated at elaboration only
    function automatic longint sin_q(input int k, input int frac);
        real r;
        r = $sin(real'(k) * PI_R / HALF_TURN) * (2.0 ** frac);
        return longint'($floor(r + 0.5));
    endfunction

    // one subtraction suffices for inputs below 720
    function automatic logic [9:0] reduce_deg(input logic [9:0] a);
        return (a >= DEG_360) ? a - DEG_360 : a;
    endfunction

    function automatic t_trig_sel fold_deg(input logic [9:0] a_in);
        logic [9:0] a;
        t_trig_sel  s;
        a = reduce_deg(a_in);
        if (a <= DEG_90) begin
            s.idx = a[6:0];            s.neg = 1'b0;
        end else if (a <= DEG_180) begin
            s.idx = 7'(DEG_180 - a);   s.neg = 1'b0;
        end else if (a <= DEG_270) begin
            s.idx = 7'(a - DEG_180);   s.neg = 1'b1;
        end else begin
            s.idx = 7'(DEG_360 - a);   s.neg = 1'b1;
        end
        return s;
    endfunction

endpackage

### rtl/core/camera_view_transform_unit.sv
// Top level: world point to camera space, X-Y-Z Euler camera, pipelined.
// Throughput: one item per cycle unless the output stalls; six stages (subtract, two align,
// multiply, add, truncate). Input ready falls only with all stages full and the output stalled.
// Angle writes rebuild the matrix in three registered steps, before any later item multiplies.
// Reset (synchronous, active low) clears valid bits and zeroes all camera registers.
`include "camera_view_transform_unit_macros.svh"
module camera_view_transform_unit #(
    parameter int COORD_BITS     = cvt_pkg::COORD_BITS_DEF,
    parameter int TRIG_FRAC_BITS = cvt_pkg::TRIG_FRAC_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // configuration write port
    input  logic                                   i_cfg_we,
    input  logic [cvt_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [((COORD_BITS > cvt_pkg::ANG_W) ? COORD_BITS : cvt_pkg::ANG_W)-1:0]
                                                   i_cfg_data,
    // input item channel
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic signed [COORD_BITS-1:0]           i_pt_x,
    input  logic signed [COORD_BITS-1:0]           i_pt_y,
    input  logic signed [COORD_BITS-1:0]           i_pt_z,
    // result item channel
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [COORD_BITS+1:0]           o_view_x,
    output logic signed [COORD_BITS+1:0]           o_view_y,
    output logic signed [COORD_BITS+1:0]           o_view_z
);

    localparam int F   = TRIG_FRAC_BITS;
    localparam int C   = COORD_BITS;
    localparam int TW  = F + 2;          // trig value, |v| <= 2^F
    localparam int PW  = 2 * F + 2;      // product of two trig values
    localparam int MW  = 3 * F + 3;      // matrix entry, Q(3F)
    localparam int DW  = C + 1;          // point minus camera
    localparam int PRW = MW + DW;        // entry times difference
    localparam int SW  = PRW + 2;        // row sum of three
    localparam int OW  = C + 2;
    localparam int SH  = 3 * F;
    localparam int NST = 6;
    localparam int AW  = cvt_pkg::ANG_W;

    // ---------------- configuration registers ----------------
    logic signed [C-1:0] r_pos_x, r_pos_y, r_pos_z;
    logic [AW-1:0]       r_ang_x, r_ang_y, r_ang_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x <= '0; r_pos_y <= '0; r_pos_z <= '0;
            r_ang_x <= '0; r_ang_y <= '0; r_ang_z <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                cvt_pkg::CFG_POS_X: r_pos_x <= i_cfg_data[C-1:0];
                cvt_pkg::CFG_POS_Y: r_pos_y <= i_cfg_data[C-1:0];
                cvt_pkg::CFG_POS_Z: r_pos_z <= i_cfg_data[C-1:0];
                cvt_pkg::CFG_ANG_X: r_ang_x <= i_cfg_data[AW-1:0];
                cvt_pkg::CFG_ANG_Y: r_ang_y <= i_cfg_data[AW-1:0];
                cvt_pkg::CFG_ANG_Z: r_ang_z <= i_cfg_data[AW-1:0];
                default: ;  // writes past the register list are dropped
            endcase
        end
    end

    // ---------------- sine table, quarter wave ----------------
    logic signed [TW-1:0] w_tab [91];
    for (genvar k = 0; k <= 90; k++) begin : g_tab
        localparam longint V = cvt_pkg::sin_q(k, F);
        assign w_tab[k] = V[TW-1:0];
    end

    function automatic logic signed [TW-1:0] trig_val(input cvt_pkg::t_trig_sel s,
                                                       input logic signed [TW-1:0] v);
        return s.neg ? -v : v;
    endfunction

    cvt_pkg::t_trig_sel w_sel_sx, w_sel_cx, w_sel_sy, w_sel_cy, w_sel_sz, w_sel_cz;
    always_comb begin
        w_sel_sx = cvt_pkg::fold_deg(10'(r_ang_x));
        w_sel_sy = cvt_pkg::fold_deg(10'(r_ang_y));
        w_sel_sz = cvt_pkg::fold_deg(10'(r_ang_z));
        // cos(a) = sin(a + 90)
        w_sel_cx = cvt_pkg::fold_deg(cvt_pkg::reduce_deg(10'(r_ang_x)) + cvt_pkg::DEG_90);
        w_sel_cy = cvt_pkg::fold_deg(cvt_pkg::reduce_deg(10'(r_ang_y)) + cvt_pkg::DEG_90);
        w_sel_cz = cvt_pkg::fold_deg(cvt_pkg::reduce_deg(10'(r_ang_z)) + cvt_pkg::DEG_90);
    end

    // matrix step 1: trig values
    logic signed [TW-1:0] r_sx, r_cx, r_sy, r_cy, r_sz, r_cz;
    always_ff @(posedge i_clk) begin
        r_sx <= trig_val(w_sel_sx, w_tab[w_sel_sx.idx]);
        r_cx <= trig_val(w_sel_cx, w_tab[w_sel_cx.idx]);
        r_sy <= trig_val(w_sel_sy, w_tab[w_sel_sy.idx]);
        r_cy <= trig_val(w_sel_cy, w_tab[w_sel_cy.idx]);
        r_sz <= trig_val(w_sel_sz, w_tab[w_sel_sz.idx]);
        r_cz <= trig_val(w_sel_cz, w_tab[w_sel_cz.idx]);
    end

    // matrix step 2: pairwise products
    logic signed [PW-1:0] r_cycz, r_cysz, r_sxsy, r_cxsy, r_sxcy, r_cxcy;
    logic signed [PW-1:0] r_cxsz, r_cxcz, r_sxsz, r_sxcz;
    logic signed [TW-1:0] r_sy2, r_sz2, r_cz2;
    always_ff @(posedge i_clk) begin
        r_cycz <= PW'(r_cy * r_cz);
        r_cysz <= PW'(r_cy * r_sz);
        r_sxsy <= PW'(r_sx * r_sy);
        r_cxsy <= PW'(r_cx * r_sy);
        r_sxcy <= PW'(r_sx * r_cy);
        r_cxcy <= PW'(r_cx * r_cy);
        r_cxsz <= PW'(r_cx * r_sz);
        r_cxcz <= PW'(r_cx * r_cz);
        r_sxsz <= PW'(r_sx * r_sz);
        r_sxcz <= PW'(r_sx * r_cz);
        r_sy2  <= r_sy;
        r_sz2  <= r_sz;
        r_cz2  <= r_cz;
    end

    // matrix step 3: entries in Q(3F)
    logic signed [PW+TW-1:0] w_t10, w_t11, w_t20, w_t21;
    always_comb begin
        w_t10 = r_sxsy * r_cz2;
        w_t11 = r_sxsy * r_sz2;
        w_t20 = r_cxsy * r_cz2;
        w_t21 = r_cxsy * r_sz2;
    end

    logic signed [MW-1:0] r_m [9];
    always_ff @(posedge i_clk) begin
        r_m[0] <= MW'(r_cycz) <<< F;
        r_m[1] <= MW'(r_cysz) <<< F;
        r_m[2] <= -(MW'(r_sy2) <<< (2 * F));
        r_m[3] <= MW'(w_t10) - (MW'(r_cxsz) <<< F);
        r_m[4] <= MW'(w_t11) + (MW'(r_cxcz) <<< F);
        r_m[5] <= MW'(r_sxcy) <<< F;
        r_m[6] <= MW'(w_t20) + (MW'(r_sxsz) <<< F);
        r_m[7] <= MW'(w_t21) - (MW'(r_sxcz) <<< F);
        r_m[8] <= MW'(r_cxcy) <<< F;
    end

    // ---------------- item pipeline control ----------------
    // a stage moves when empty or when the stage after it moves
    logic [NST:1] r_vld;
    logic [NST:1] w_en;

    always_comb begin
        w_en[NST] = !r_vld[NST] || i_out_ready;
        for (int k = NST - 1; k >= 1; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[1]) begin
                r_vld[1] <= i_in_valid;
            end
            for (int k = 2; k <= NST; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_in_ready  = w_en[1];
    assign o_out_valid = r_vld[NST];

    // ---------------- item datapath ----------------
    // stage 1: subtract camera position
    logic signed [DW-1:0] r_d1 [3];
    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_d1[0] <= DW'(i_pt_x) - DW'(r_pos_x);
            r_d1[1] <= DW'(i_pt_y) - DW'(r_pos_y);
            r_d1[2] <= DW'(i_pt_z) - DW'(r_pos_z);
        end
    end

    // stages 2 and 3: alignment with the matrix build after a write
    logic signed [DW-1:0] r_d2 [3];
    logic signed [DW-1:0] r_d3 [3];
    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_d2 <= r_d1;
        end
        if (w_en[3]) begin
            r_d3 <= r_d2;
        end
    end

    // stage 4: nine products, row r uses entries 3r..3r+2
    logic signed [PRW-1:0] r_p [9];
    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            for (int i = 0; i < 9; i++) begin
                r_p[i] <= PRW'(r_m[i] * r_d3[i % 3]);
            end
        end
    end

    // stage 5: row sums
    logic signed [SW-1:0] r_s [3];
    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            for (int r = 0; r < 3; r++) begin
                r_s[r] <= SW'(r_p[3*r]) + SW'(r_p[3*r+1]) + SW'(r_p[3*r+2]);
            end
        end
    end

    // stage 6: truncate toward zero, bias negatives before the arithmetic shift
    logic signed [SW-1:0] w_tr [3];
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            w_tr[r] = (r_s[r] + (r_s[r][SW-1] ? SW'((SW'(1) << SH) - SW'(1)) : SW'(0)))
                      >>> SH;
        end
    end

    logic signed [OW-1:0] r_out [3];
    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            for (int r = 0; r < 3; r++) begin
                r_out[r] <= w_tr[r][OW-1:0];
            end
        end
    end

    assign o_view_x = r_out[0];
    assign o_view_y = r_out[1];
    assign o_view_z = r_out[2];

    // ---------------- checks ----------------
    `CVT_ASSERT_NEXT(a_accept_enters, i_in_valid && o_in_ready, r_vld[1])
    `CVT_ASSERT_NOW(a_empty_tail_ready, !r_vld[NST], o_in_ready)
    `CVT_ASSERT_NEXT(a_count_up, i_in_valid && o_in_ready && !(o_out_valid && i_out_ready), $countones(r_vld) == $past($countones(r_vld)) + 1)
    `CVT_ASSERT_NEXT(a_count_down, !(i_in_valid && o_in_ready) && o_out_valid && i_out_ready, $countones(r_vld) + 1 == $past($countones(r_vld)))

endmodule
